FILE: hw/rtl/ws2812rb_pkg.sv
// Shared types, constants and color helpers for the WS2812 rainbow driver.
package ws2812rb_pkg;

  localparam int LED_COUNT_DEF = 4;
  localparam int BITS_PER_LED  = 24;
  localparam int STEP_W        = 16;
  localparam int DIV_W         = 24;
  localparam int ADDR_W        = 5;
  localparam int DATA_W        = 32;

  localparam logic [7:0] COLOR_VAL   = 8'h80;
  localparam logic [7:0] COLOR_FULL  = 8'd255;
  localparam logic [7:0] SECTOR_SPAN = 8'd43;
  localparam logic [7:0] REM_SCALE   = 8'd6;

  // G:R:B of hue zero
  localparam logic [23:0] FIRST_COLOR = {8'h00, COLOR_VAL, 8'h00};

  typedef enum logic [2:0] {
    REG_STEP_COUNT,
    REG_HOLD,
    REG_ZERO_HIGH,
    REG_ZERO_LOW,
    REG_ONE_HIGH,
    REG_ONE_LOW,
    REG_LATCH
  } reg_idx_t;

  typedef struct packed {
    logic [STEP_W-1:0] step_count;
    logic [31:0]       hold_ticks;
    logic [7:0]        zero_high_ticks;
    logic [7:0]        zero_low_ticks;
    logic [7:0]        one_high_ticks;
    logic [7:0]        one_low_ticks;
    logic [15:0]       latch_ticks;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    step_count:      16'd256,
    hold_ticks:      32'd1000000,
    zero_high_ticks: 8'd20,
    zero_low_ticks:  8'd43,
    one_high_ticks:  8'd40,
    one_low_ticks:   8'd22,
    latch_ticks:     16'd3000
  };

  typedef enum logic [2:0] {
    DUR_DEC,
    DUR_LOW,
    DUR_HIGH,
    DUR_LOAD,
    DUR_LATCH,
    DUR_HOLD,
    DUR_ZERO
  } dur_sel_t;

  typedef struct packed {
    logic     load_first;
    logic     load_next;
    logic     shift;
    logic     dur_we;
    dur_sel_t dur_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic       dec_zero;
    logic       bit_last;
    logic       led_last;
    logic       step_last;
    logic       hold_zero;
    logic       div_busy;
    logic [7:0] hue;
  } dp_stat_t;

  typedef enum logic [2:0] {
    SEC_RY,
    SEC_YG,
    SEC_GC,
    SEC_CB,
    SEC_BM,
    SEC_MR
  } sector_t;

  function automatic logic [31:0] at_least_one(input logic [31:0] v);
    return (v == '0) ? 32'd1 : v;
  endfunction

  // Six-sector HSV color at full saturation and fixed value, packed G:R:B.
  function automatic logic [23:0] hsv_color(input logic [7:0] h);
    sector_t    sec;
    logic [7:0] base;
    logic [7:0] rem;
    logic [7:0] q;
    logic [7:0] t;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    if (h >= 8'(5 * SECTOR_SPAN)) begin
      sec = SEC_MR; base = 8'(5 * SECTOR_SPAN);
    end else if (h >= 8'(4 * SECTOR_SPAN)) begin
      sec = SEC_BM; base = 8'(4 * SECTOR_SPAN);
    end else if (h >= 8'(3 * SECTOR_SPAN)) begin
      sec = SEC_CB; base = 8'(3 * SECTOR_SPAN);
    end else if (h >= 8'(2 * SECTOR_SPAN)) begin
      sec = SEC_GC; base = 8'(2 * SECTOR_SPAN);
    end else if (h >= SECTOR_SPAN) begin
      sec = SEC_YG; base = SECTOR_SPAN;
    end else begin
      sec = SEC_RY; base = 8'd0;
    end
    rem = 8'((h - base) * REM_SCALE);
    q   = (COLOR_FULL - rem) >> 1;
    t   = rem >> 1;
    case (sec)
      SEC_RY: begin r = COLOR_VAL; g = t;         b = 8'd0;      end
      SEC_YG: begin r = q;         g = COLOR_VAL; b = 8'd0;      end
      SEC_GC: begin r = 8'd0;      g = COLOR_VAL; b = t;         end
      SEC_CB: begin r = 8'd0;      g = q;         b = COLOR_VAL; end
      SEC_BM: begin r = t;         g = 8'd0;      b = COLOR_VAL; end
      default: begin r = COLOR_VAL; g = 8'd0;     b = q;         end
    endcase
    return {g, r, b};
  endfunction

endpackage

FILE: hw/rtl/ws2812rb_ifs.sv
// Valid/ready channel interfaces for tick items and result items.
interface ws2812rb_cmd_if;
  logic valid;
  logic ready;
  logic start_req;
  logic stop;

  modport source (output valid, output start_req, output stop, input ready);
  modport sink (input valid, input start_req, input stop, output ready);
endinterface

interface ws2812rb_res_if;
  logic       valid;
  logic       ready;
  logic       line;
  logic       busy_res;
  logic [7:0] hue;
  logic       step_done;
  logic       cycle_done;

  modport source (output valid, output line, output busy_res, output hue,
                  output step_done, output cycle_done, input ready);
  modport sink (input valid, input line, input busy_res, input hue,
                input step_done, input cycle_done, output ready);
endinterface

FILE: hw/rtl/ws2812rb_regs.sv
// APB-style configuration register file.
module ws2812rb_regs import ws2812rb_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (wr) begin
      unique case (idx)
        REG_STEP_COUNT: cfg.step_count      <= pwdata[STEP_W-1:0];
        REG_HOLD:       cfg.hold_ticks      <= pwdata[31:0];
        REG_ZERO_HIGH:  cfg.zero_high_ticks <= pwdata[7:0];
        REG_ZERO_LOW:   cfg.zero_low_ticks  <= pwdata[7:0];
        REG_ONE_HIGH:   cfg.one_high_ticks  <= pwdata[7:0];
        REG_ONE_LOW:    cfg.one_low_ticks   <= pwdata[7:0];
        REG_LATCH:      cfg.latch_ticks     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_STEP_COUNT: prdata = DATA_W'(cfg.step_count);
      REG_HOLD:       prdata = DATA_W'(cfg.hold_ticks);
      REG_ZERO_HIGH:  prdata = DATA_W'(cfg.zero_high_ticks);
      REG_ZERO_LOW:   prdata = DATA_W'(cfg.zero_low_ticks);
      REG_ONE_HIGH:   prdata = DATA_W'(cfg.one_high_ticks);
      REG_ONE_LOW:    prdata = DATA_W'(cfg.one_low_ticks);
      REG_LATCH:      prdata = DATA_W'(cfg.latch_ticks);
      default:        prdata = '0;
    endcase
  end

endmodule

FILE: hw/rtl/ws2812rb_div.sv
// Restoring divider, one quotient bit per cycle, for the next step's hue.
module ws2812rb_div import ws2812rb_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              go,
  input  logic [DIV_W-1:0]  num,
  input  logic [STEP_W-1:0] den,
  output logic              busy,
  output logic [7:0]        quo
);

  localparam int CntW = $clog2(DIV_W + 1);

  logic [DIV_W-1:0]  acc;
  logic [STEP_W-1:0] part;
  logic [CntW-1:0]   cnt;
  logic [STEP_W:0]   trial;
  logic              fits;

  assign trial = {part, acc[DIV_W-1]};
  assign fits  = trial >= {1'b0, den};
  assign quo   = acc[7:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (go) begin
      busy <= 1'b1;
      cnt  <= CntW'(DIV_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CntW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // acc shifts the dividend out at the top and the quotient in at the bottom
  always_ff @(posedge clk) begin
    if (go) begin
      acc  <= num;
      part <= '0;
    end else if (busy) begin
      acc  <= {acc[DIV_W-2:0], fits};
      part <= fits ? STEP_W'(trial - {1'b0, den}) : trial[STEP_W-1:0];
    end
  end

endmodule

FILE: hw/rtl/ws2812rb_dp.sv
// Datapath: step and hue registers, bit shifter, LED and bit counters, tick timer.
module ws2812rb_dp import ws2812rb_pkg::*; #(
  parameter int LED_COUNT = LED_COUNT_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  cfg_t     cfg,
  input  dp_cmd_t  ctl,
  output dp_stat_t stat
);

  localparam int LedW = $clog2(LED_COUNT + 1);
  localparam int BitW = $clog2(BITS_PER_LED);

  logic [STEP_W-1:0] step_index;
  logic [STEP_W-1:0] steps_latched;
  logic [7:0]        cur_hue;
  logic [23:0]       color_word;
  logic [23:0]       shift_word;
  logic [BitW-1:0]   bit_index;
  logic [LedW-1:0]   led_index;
  logic [31:0]       duration_left;
  logic              div_go;
  logic [DIV_W-1:0]  div_num;
  logic [STEP_W-1:0] div_den;
  logic              div_run;
  logic [7:0]        next_hue;

  logic [31:0]       eff_dur;
  logic [31:0]       dec;
  logic              eff_msb;
  logic              bit_last;
  logic [23:0]       sh_new;
  logic [23:0]       color_n;
  logic [31:0]       dur_next;
  logic [STEP_W-1:0] num_n;

  always_comb begin
    // on the start item the first bit of hue zero is already on the line
    eff_dur  = ctl.load_first
             ? at_least_one(32'(FIRST_COLOR[23] ? cfg.one_high_ticks : cfg.zero_high_ticks))
             : duration_left;
    eff_msb  = ctl.load_first ? FIRST_COLOR[23] : shift_word[23];
    dec      = eff_dur - 32'(eff_dur != '0);
    bit_last = bit_index == BitW'(BITS_PER_LED - 1);
    sh_new   = bit_last ? color_word : {shift_word[22:0], 1'b0};
    color_n  = hsv_color(next_hue);
    num_n    = ctl.load_first ? STEP_W'(1) : step_index + STEP_W'(2);

    case (ctl.dur_sel)
      DUR_LOW:   dur_next = at_least_one(32'(eff_msb ? cfg.one_low_ticks
                                                     : cfg.zero_low_ticks));
      DUR_HIGH:  dur_next = at_least_one(32'(sh_new[23] ? cfg.one_high_ticks
                                                        : cfg.zero_high_ticks));
      DUR_LOAD:  dur_next = at_least_one(32'(color_n[23] ? cfg.one_high_ticks
                                                         : cfg.zero_high_ticks));
      DUR_LATCH: dur_next = at_least_one(32'(cfg.latch_ticks));
      DUR_HOLD:  dur_next = cfg.hold_ticks;
      DUR_ZERO:  dur_next = '0;
      default:   dur_next = dec;
    endcase
  end

  always_comb begin
    stat.dec_zero  = dec == '0;
    stat.bit_last  = bit_last;
    stat.led_last  = (led_index + 1'b1) == LedW'(LED_COUNT);
    stat.step_last = ({1'b0, step_index} + 1'b1) >= {1'b0, steps_latched};
    stat.hold_zero = cfg.hold_ticks == '0;
    stat.div_busy  = div_go || div_run;
    stat.hue       = ctl.load_first ? 8'd0 : cur_hue;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_go <= 1'b0;
    end else begin
      div_go <= ctl.load_first || ctl.load_next;
    end
  end

  always_ff @(posedge clk) begin
    // queue the hue of the step after the one being loaded: (n * 255) / steps
    if (ctl.load_first || ctl.load_next) begin
      div_num <= DIV_W'({num_n, 8'h00}) - DIV_W'(num_n);
      div_den <= ctl.load_first ? cfg.step_count : steps_latched;
    end
    if (ctl.load_first) begin
      steps_latched <= cfg.step_count;
      step_index    <= '0;
      cur_hue       <= '0;
      color_word    <= FIRST_COLOR;
      shift_word    <= FIRST_COLOR;
      bit_index     <= '0;
      led_index     <= '0;
    end
    if (ctl.load_next) begin
      step_index <= step_index + 1'b1;
      cur_hue    <= next_hue;
      color_word <= color_n;
      shift_word <= color_n;
      bit_index  <= '0;
      led_index  <= '0;
    end
    if (ctl.shift) begin
      shift_word <= sh_new;
      if (bit_last) begin
        bit_index <= '0;
        led_index <= led_index + 1'b1;
      end else begin
        bit_index <= bit_index + 1'b1;
      end
    end
    if (ctl.dur_we) begin
      duration_left <= dur_next;
    end
  end

  ws2812rb_div u_div (
    .clk  (clk),
    .rst  (rst),
    .go   (div_go),
    .num  (div_num),
    .den  (div_den),
    .busy (div_run),
    .quo  (next_hue)
  );

endmodule

FILE: hw/rtl/ws2812rb_ctrl.sv
// Waveform phase controller and registered result stage.
module ws2812rb_ctrl import ws2812rb_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  ws2812rb_cmd_if.sink    cmd,
  ws2812rb_res_if.source  res,
  input  logic            step_count_nz,
  input  dp_stat_t        stat,
  output dp_cmd_t         ctl
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HIGH,
    PH_LOW,
    PH_LATCH,
    PH_HOLD
  } phase_t;

  phase_t phase;
  phase_t phase_next;
  phase_t eff_phase;
  logic   res_valid;
  logic   fire;
  logic   start_now;
  logic   active;
  logic   end_step;
  logic   step_done_next;
  logic   cycle_done_next;

  // hold tick items at a step boundary until the next hue is ready
  assign cmd.ready = (!res_valid || res.ready)
                   && !(stat.div_busy && (phase == PH_LATCH || phase == PH_HOLD));
  assign fire      = cmd.valid && cmd.ready;
  assign res.valid = res_valid;

  always_comb begin
    start_now = fire && !cmd.stop && (phase == PH_IDLE) && cmd.start_req && step_count_nz;
    eff_phase = start_now ? PH_HIGH : phase;
    active    = fire && !cmd.stop && (eff_phase != PH_IDLE);

    phase_next      = phase;
    ctl             = '0;
    ctl.dur_sel     = DUR_DEC;
    end_step        = 1'b0;
    step_done_next  = 1'b0;
    cycle_done_next = 1'b0;

    if (fire && cmd.stop) begin
      phase_next  = PH_IDLE;
      ctl.dur_we  = 1'b1;
      ctl.dur_sel = DUR_ZERO;
    end else if (active) begin
      ctl.load_first = start_now;
      ctl.dur_we     = 1'b1;
      phase_next     = eff_phase;
      if (stat.dec_zero) begin
        unique case (eff_phase)
          PH_HIGH: begin
            phase_next  = PH_LOW;
            ctl.dur_sel = DUR_LOW;
          end
          PH_LOW: begin
            ctl.shift = 1'b1;
            if (stat.bit_last && stat.led_last) begin
              phase_next  = PH_LATCH;
              ctl.dur_sel = DUR_LATCH;
            end else begin
              phase_next  = PH_HIGH;
              ctl.dur_sel = DUR_HIGH;
            end
          end
          PH_LATCH: begin
            if (!stat.hold_zero) begin
              phase_next  = PH_HOLD;
              ctl.dur_sel = DUR_HOLD;
            end else begin
              end_step = 1'b1;
            end
          end
          PH_HOLD: end_step = 1'b1;
          default: ;
        endcase
      end
      if (end_step) begin
        step_done_next = 1'b1;
        if (stat.step_last) begin
          cycle_done_next = 1'b1;
          phase_next      = PH_IDLE;
          ctl.dur_sel     = DUR_ZERO;
        end else begin
          ctl.load_next = 1'b1;
          phase_next    = PH_HIGH;
          ctl.dur_sel   = DUR_LOAD;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      res_valid <= 1'b0;
    end else begin
      phase <= phase_next;
      if (fire) begin
        res_valid      <= 1'b1;
        res.line       <= active && (eff_phase == PH_HIGH);
        res.busy_res   <= active;
        res.hue        <= active ? stat.hue : 8'd0;
        res.step_done  <= step_done_next;
        res.cycle_done <= cycle_done_next;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: hw/rtl/ws2812_rainbow_led_driver.sv
// WS2812 rainbow driver top level: register file, controller and datapath.
//
//   channel   dir  handshake           payload
//   cmd       in   valid/ready         start_req, stop (one item per waveform tick)
//   res       out  valid/ready         line, busy_res, hue, step_done, cycle_done
//   apb       in   psel/penable/pready step_count, hold_ticks, bit and latch timing
//
// Each accepted tick item yields one result item, registered in the result stage.
// A step's hue comes from a restoring divider started when the previous step loads;
// tick input waits at a step boundary while it is still running.
// The result register takes a new item while the held one is taken in the same cycle.
// Synchronous reset leaves the block idle with registers at their reset values.
module ws2812_rainbow_led_driver import ws2812rb_pkg::*; #(
  parameter int LED_COUNT = LED_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst,
  ws2812rb_cmd_if.sink      cmd,
  ws2812rb_res_if.source    res,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t     cfg;
  dp_cmd_t  ctl;
  dp_stat_t stat;
  logic     step_count_nz;

  assign step_count_nz = cfg.step_count != '0;

  ws2812rb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ws2812rb_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .res           (res),
    .step_count_nz (step_count_nz),
    .stat          (stat),
    .ctl           (ctl)
  );

  ws2812rb_dp #(
    .LED_COUNT (LED_COUNT)
  ) u_dp (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .ctl  (ctl),
    .stat (stat)
  );

endmodule
